>>> rtl/mavg_pkg.sv
// Shared constants for the moving average block with limit alarms.
// Holds widths, register indexes and alarm codes; no dependencies.
package mavg_pkg;

    // Sample width and window length; WINDOW must be a power of two.
    localparam int SAMPLE_BITS = 24;
    localparam int WINDOW      = 16;

    localparam int WIN_SHIFT  = $clog2(WINDOW);
    localparam int SLOT_W     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int SUM_W      = SAMPLE_BITS + WIN_SHIFT + 1;
    localparam int HYST_W     = SAMPLE_BITS - 1;
    localparam int CMP_W      = SAMPLE_BITS + 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = SAMPLE_BITS;
    localparam int SEV_FLD_W  = 8;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HIHI       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOW        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LOLO       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HYST       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SEVERITIES = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_VALUE_DB   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_ARCHIVE_DB = 3'd7;

    // Alarm status codes
    localparam logic [2:0] ST_NONE  = 3'd0;
    localparam logic [2:0] ST_HIHI  = 3'd1;
    localparam logic [2:0] ST_LOLO  = 3'd2;
    localparam logic [2:0] ST_HIGH  = 3'd3;
    localparam logic [2:0] ST_LOW   = 3'd4;
    localparam logic [2:0] ST_UNDEF = 3'd5;

    // Alarm severity codes
    localparam logic [1:0] SEV_NONE    = 2'd0;
    localparam logic [1:0] SEV_INVALID = 2'd3;

endpackage

>>> rtl/moving_average_with_alarms.sv
// Top level of the boxcar moving average with limit alarms and deadband flags.
// Depends on mavg_pkg for widths, register indexes and alarm codes.
// Checker mavg_checker binds to this module from a separate file.
//
// Usage:
//   Input channel (s_valid / s_ready / s_sample) takes one signed sample per
//   word. Result channel (m_valid / m_ready / m_*) returns exactly one word
//   per sample: the window average (sum of the last WINDOW samples divided by
//   WINDOW, truncated toward zero), the alarm status and severity from the
//   hihi, lolo, high and low limits with hysteresis, an alarm-change flag and
//   the value and archive deadband flags.
//   Configuration: cfg_wr_en writes cfg_data into register cfg_index at the
//   clock edge; write only while no word is in flight.
//   Path: a sample accepted at the input is registered in stage A, then in
//   the result register, and only then shows up on the result port.
//   Throughput: one word per cycle while m_ready stays high, limited by the
//   ring read and running-sum update (stage A) and by the alarm compares,
//   which feed back into the last alarm value in the same cycle (stage B).
//   Stall: when m_ready is low the result word holds; stage A still takes
//   one more sample, then s_ready drops until the result register drains.
//   Reset (aresetn low, synchronous): ring, sum, last values and all config
//   registers clear and the slot goes to WINDOW-1; the first result after
//   reset reports status undefined with severity invalid.
module moving_average_with_alarms
    import mavg_pkg::*;
(
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration write port
    input  logic                          cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data,
    // sample input channel
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [SAMPLE_BITS-1:0] s_sample,
    // result channel
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [SAMPLE_BITS-1:0] m_average,
    output logic [2:0]                    m_alarm_status,
    output logic [1:0]                    m_alarm_severity,
    output logic                          m_alarm_changed,
    output logic                          m_value_event,
    output logic                          m_archive_event
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic signed [SAMPLE_BITS-1:0] hihi_reg, high_reg, low_reg, lolo_reg;
    logic [HYST_W-1:0]             hyst_reg;
    logic [SEV_FLD_W-1:0]          sev_cfg_reg;
    logic [SAMPLE_BITS-1:0]        value_db_reg, archive_db_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hihi_reg       <= '0;
            high_reg       <= '0;
            low_reg        <= '0;
            lolo_reg       <= '0;
            hyst_reg       <= '0;
            sev_cfg_reg    <= '0;
            value_db_reg   <= '0;
            archive_db_reg <= '0;
        end else if (cfg_wr_en) begin
            // drop the bits above each register's width
            unique case (cfg_index)
                REG_HIHI:       hihi_reg       <= cfg_data[SAMPLE_BITS-1:0];
                REG_HIGH:       high_reg       <= cfg_data[SAMPLE_BITS-1:0];
                REG_LOW:        low_reg        <= cfg_data[SAMPLE_BITS-1:0];
                REG_LOLO:       lolo_reg       <= cfg_data[SAMPLE_BITS-1:0];
                REG_HYST:       hyst_reg       <= cfg_data[HYST_W-1:0];
                REG_SEVERITIES: sev_cfg_reg    <= cfg_data[SEV_FLD_W-1:0];
                REG_VALUE_DB:   value_db_reg   <= cfg_data[SAMPLE_BITS-1:0];
                REG_ARCHIVE_DB: archive_db_reg <= cfg_data[SAMPLE_BITS-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake: two-stage pipeline, each stage advances when the next
    // one is empty or draining this cycle.
    // ------------------------------------------------------------------
    logic a_valid_reg;
    logic m_valid_reg;
    logic b_load;
    logic s_accept;

    assign b_load   = a_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready  = !a_valid_reg || b_load;
    assign s_accept = s_valid && s_ready;
    assign m_valid  = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (s_accept) begin
                a_valid_reg <= 1'b1;
            end else if (b_load) begin
                a_valid_reg <= 1'b0;
            end
            if (b_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage A: ring of samples, running sum, average
    // ------------------------------------------------------------------
    logic signed [SAMPLE_BITS-1:0] ring_reg [WINDOW];
    logic [SLOT_W-1:0]             slot_reg;
    logic [SLOT_W-1:0]             slot_next;
    logic signed [SUM_W-1:0]       sum_reg;
    logic signed [SUM_W-1:0]       sum_next;
    logic signed [SUM_W-1:0]       sum_biased;
    logic signed [SUM_W-1:0]       sum_shifted;
    logic signed [SAMPLE_BITS-1:0] avg_a_reg;

    always_comb begin
        // advance the write slot, wrapping at the end of the window
        if (slot_reg == SLOT_W'(WINDOW - 1)) begin
            slot_next = '0;
        end else begin
            slot_next = slot_reg + 1'b1;
        end
        sum_next = sum_reg + SUM_W'(s_sample) - SUM_W'(ring_reg[slot_next]);
        // bias negative sums so the shift truncates toward zero
        if (sum_next < 0) begin
            sum_biased = sum_next + SUM_W'(WINDOW - 1);
        end else begin
            sum_biased = sum_next;
        end
        sum_shifted = sum_biased >>> WIN_SHIFT;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg <= SLOT_W'(WINDOW - 1);
            sum_reg  <= '0;
            for (int i = 0; i < WINDOW; i++) begin
                ring_reg[i] <= '0;
            end
        end else if (s_accept) begin
            slot_reg            <= slot_next;
            sum_reg             <= sum_next;
            ring_reg[slot_next] <= s_sample;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            avg_a_reg <= sum_shifted[SAMPLE_BITS-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Stage B: limit alarms with hysteresis, deadband flags
    // ------------------------------------------------------------------
    logic signed [SAMPLE_BITS-1:0] last_alarm_reg;
    logic signed [SAMPLE_BITS-1:0] last_alarm_next;
    logic signed [SAMPLE_BITS-1:0] last_mon_reg;
    logic signed [SAMPLE_BITS-1:0] last_arch_reg;
    logic                          undef_reg;
    logic [2:0]                    prev_status_reg;
    logic [1:0]                    prev_sev_reg;

    logic [1:0]              hh_sev, ll_sev, h_sev, l_sev;
    logic signed [CMP_W-1:0] avg_w, hihi_w, high_w, low_w, lolo_w, hyst_w;
    logic signed [CMP_W-1:0] vdb_w, adb_w, mon_diff, arch_diff;
    logic                    hh_hit, ll_hit, h_hit, l_hit;
    logic [2:0]              status_next;
    logic [1:0]              sev_next;
    logic                    vev_next, aev_next;

    assign hh_sev = sev_cfg_reg[1:0];
    assign ll_sev = sev_cfg_reg[3:2];
    assign h_sev  = sev_cfg_reg[5:4];
    assign l_sev  = sev_cfg_reg[7:6];

    always_comb begin
        // widen everything so limit +/- hysteresis cannot wrap
        avg_w  = CMP_W'(avg_a_reg);
        hihi_w = CMP_W'(hihi_reg);
        high_w = CMP_W'(high_reg);
        low_w  = CMP_W'(low_reg);
        lolo_w = CMP_W'(lolo_reg);
        hyst_w = $signed({{(CMP_W - HYST_W){1'b0}}, hyst_reg});
        vdb_w  = $signed({{(CMP_W - SAMPLE_BITS){1'b0}}, value_db_reg});
        adb_w  = $signed({{(CMP_W - SAMPLE_BITS){1'b0}}, archive_db_reg});

        // a limit stays active inside its hysteresis band once it was the
        // last alarm value
        hh_hit = (hh_sev != SEV_NONE) && ((avg_w >= hihi_w) ||
                 ((last_alarm_reg == hihi_reg) && (avg_w >= hihi_w - hyst_w)));
        ll_hit = (ll_sev != SEV_NONE) && ((avg_w <= lolo_w) ||
                 ((last_alarm_reg == lolo_reg) && (avg_w <= lolo_w + hyst_w)));
        h_hit  = (h_sev != SEV_NONE) && ((avg_w >= high_w) ||
                 ((last_alarm_reg == high_reg) && (avg_w >= high_w - hyst_w)));
        l_hit  = (l_sev != SEV_NONE) && ((avg_w <= low_w) ||
                 ((last_alarm_reg == low_reg) && (avg_w <= low_w + hyst_w)));

        // priority: hihi, lolo, high, low
        if (undef_reg) begin
            status_next     = ST_UNDEF;
            sev_next        = SEV_INVALID;
            last_alarm_next = last_alarm_reg;
        end else if (hh_hit) begin
            status_next     = ST_HIHI;
            sev_next        = hh_sev;
            last_alarm_next = hihi_reg;
        end else if (ll_hit) begin
            status_next     = ST_LOLO;
            sev_next        = ll_sev;
            last_alarm_next = lolo_reg;
        end else if (h_hit) begin
            status_next     = ST_HIGH;
            sev_next        = h_sev;
            last_alarm_next = high_reg;
        end else if (l_hit) begin
            status_next     = ST_LOW;
            sev_next        = l_sev;
            last_alarm_next = low_reg;
        end else begin
            status_next     = ST_NONE;
            sev_next        = SEV_NONE;
            last_alarm_next = avg_a_reg;
        end

        // deadband: flag when the distance to the last flagged value exceeds it
        mon_diff  = CMP_W'(last_mon_reg) - avg_w;
        arch_diff = CMP_W'(last_arch_reg) - avg_w;
        vev_next  = (mon_diff > vdb_w) || (-mon_diff > vdb_w);
        aev_next  = (arch_diff > adb_w) || (-arch_diff > adb_w);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_alarm_reg  <= '0;
            last_mon_reg    <= '0;
            last_arch_reg   <= '0;
            undef_reg       <= 1'b1;
            prev_status_reg <= ST_NONE;
            prev_sev_reg    <= SEV_NONE;
        end else if (b_load) begin
            last_alarm_reg  <= last_alarm_next;
            undef_reg       <= 1'b0;
            prev_status_reg <= status_next;
            prev_sev_reg    <= sev_next;
            if (vev_next) begin
                last_mon_reg <= avg_a_reg;
            end
            if (aev_next) begin
                last_arch_reg <= avg_a_reg;
            end
        end
    end

    // Result register: hold while the receiver stalls
    logic signed [SAMPLE_BITS-1:0] avg_out_reg;
    logic [2:0]                    status_out_reg;
    logic [1:0]                    sev_out_reg;
    logic                          changed_out_reg;
    logic                          vev_out_reg;
    logic                          aev_out_reg;

    always_ff @(posedge aclk) begin
        if (b_load) begin
            avg_out_reg     <= avg_a_reg;
            status_out_reg  <= status_next;
            sev_out_reg     <= sev_next;
            changed_out_reg <= (status_next != prev_status_reg) ||
                               (sev_next != prev_sev_reg);
            vev_out_reg     <= vev_next;
            aev_out_reg     <= aev_next;
        end
    end

    assign m_average        = avg_out_reg;
    assign m_alarm_status   = status_out_reg;
    assign m_alarm_severity = sev_out_reg;
    assign m_alarm_changed  = changed_out_reg;
    assign m_value_event    = vev_out_reg;
    assign m_archive_event  = aev_out_reg;

endmodule

>>> rtl/mavg_checker.sv
// Port-level checker for moving_average_with_alarms, bound to the top level.
// Depends on mavg_pkg for alarm codes.
module mavg_checker
    import mavg_pkg::*;
(
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic signed [SAMPLE_BITS-1:0] m_average,
    input logic [2:0]                    m_alarm_status,
    input logic [1:0]                    m_alarm_severity,
    input logic                          m_alarm_changed
);

    logic       out_acc;
    logic       seen_reg;
    logic [2:0] prev_st_reg;
    logic [1:0] prev_sev_reg;

    assign out_acc = m_valid && m_ready;

    // track the last delivered alarm word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg     <= 1'b0;
            prev_st_reg  <= ST_NONE;
            prev_sev_reg <= SEV_NONE;
        end else if (out_acc) begin
            seen_reg     <= 1'b1;
            prev_st_reg  <= m_alarm_status;
            prev_sev_reg <= m_alarm_severity;
        end
    end

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_average) &&
        $stable(m_alarm_status) && $stable(m_alarm_severity))
        else $error("result word changed while stalled");

    a_first_undef: assert property (@(posedge aclk) disable iff (!aresetn)
        out_acc && !seen_reg |->
        (m_alarm_status == ST_UNDEF) && (m_alarm_severity == SEV_INVALID))
        else $error("first word after reset not undefined");

    a_later_defined: assert property (@(posedge aclk) disable iff (!aresetn)
        out_acc && seen_reg |-> m_alarm_status != ST_UNDEF)
        else $error("undefined status after first word");

    a_sev_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_alarm_status == ST_NONE) == (m_alarm_severity == SEV_NONE)))
        else $error("severity inconsistent with status");

    a_changed: assert property (@(posedge aclk) disable iff (!aresetn)
        out_acc |-> m_alarm_changed ==
        ((m_alarm_status != prev_st_reg) || (m_alarm_severity != prev_sev_reg)))
        else $error("alarm change flag wrong");

endmodule

bind moving_average_with_alarms mavg_checker u_mavg_checker (.*);

>>> dv/tb.sv
// Testbench for moving_average_with_alarms: boxcar average, limit alarms, deadband flags.
// Predicts every result word from a local copy of window, alarm and deadband state.
// Depends on rtl/mavg_pkg.sv and rtl/moving_average_with_alarms.sv.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import mavg_pkg::*;

    localparam int     NUM_REGS    = 8;
    localparam int     STALL_LIMIT = 2000;
    localparam longint SAMPLE_MAX  = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
    localparam longint SAMPLE_MIN  = -(longint'(1) << (SAMPLE_BITS - 1));

    // One result word as it leaves the block.
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] average;
        logic [2:0]                    status;
        logic [1:0]                    severity;
        logic                          changed;
        logic                          value_ev;
        logic                          archive_ev;
    } mavg_word_t;

    // Receiver behavior: always ready, random stalls, or a fixed duty pattern.
    typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_t;

    logic                          aclk      = 1'b0;
    logic                          aresetn   = 1'b0;
    logic                          cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]          cfg_index = '0;
    logic [CFG_DATA_W-1:0]         cfg_data  = '0;
    logic                          s_valid   = 1'b0;
    logic                          s_ready;
    logic signed [SAMPLE_BITS-1:0] s_sample  = '0;
    logic                          m_valid;
    logic                          m_ready   = 1'b0;
    logic signed [SAMPLE_BITS-1:0] m_average;
    logic [2:0]                    m_alarm_status;
    logic [1:0]                    m_alarm_severity;
    logic                          m_alarm_changed;
    logic                          m_value_event;
    logic                          m_archive_event;

    moving_average_with_alarms dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_sample        (s_sample),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_average       (m_average),
        .m_alarm_status  (m_alarm_status),
        .m_alarm_severity(m_alarm_severity),
        .m_alarm_changed (m_alarm_changed),
        .m_value_event   (m_value_event),
        .m_archive_event (m_archive_event)
    );

    // ------------------------------------------------------------------
    // Predicted block state (window, alarm memory, deadband memory)
    // ------------------------------------------------------------------
    logic signed [SAMPLE_BITS-1:0] window_ring [WINDOW];
    longint     window_total     = 0;
    int         window_slot      = WINDOW - 1;
    longint     alarm_memory     = 0;
    longint     monitored_value  = 0;
    longint     archived_value   = 0;
    bit         awaiting_define  = 1'b1;
    logic [2:0] prior_status     = ST_NONE;
    logic [1:0] prior_severity   = SEV_NONE;

    // Register contents as the block holds them (after masking and sign extension).
    longint     hihi_level  = 0;
    longint     high_level  = 0;
    longint     low_level   = 0;
    longint     lolo_level  = 0;
    longint     hyst_margin = 0;
    logic [7:0] limit_sevs  = '0;
    longint     value_band  = 0;
    longint     archive_band = 0;

    // Raw words to be written by the next configuration pass, indexed by register.
    logic [NUM_REGS-1:0][CFG_DATA_W-1:0] cfg_next = '0;

    mavg_word_t awaited_words[$];
    int         mismatches  = 0;
    bit         tx_bursty   = 1'b0;
    int         burst_left  = 0;
    rx_mode_t   rx_mode     = RX_ALWAYS;
    int         holdoff_len = 0;

    initial begin
        forever #1 aclk = ~aclk;
    end

    // Advance the window by one sample and work out the word the block must return.
    function automatic mavg_word_t next_average_word(input logic signed [SAMPLE_BITS-1:0] x);
        mavg_word_t w;
        longint     avg;
        longint     gap;
        logic [1:0] hh_sev;
        logic [1:0] ll_sev;
        logic [1:0] hi_sev;
        logic [1:0] lo_sev;
        hh_sev = limit_sevs[1:0];
        ll_sev = limit_sevs[3:2];
        hi_sev = limit_sevs[5:4];
        lo_sev = limit_sevs[7:6];

        // Replace the oldest sample and keep the exact total.
        window_slot  = (window_slot + 1) % WINDOW;
        window_total = window_total + longint'(x) - longint'(window_ring[window_slot]);
        window_ring[window_slot] = x;
        avg = window_total / WINDOW;    // signed division truncates toward zero

        w          = '0;
        w.status   = ST_NONE;
        w.severity = SEV_NONE;
        // Check in priority order; an active limit stays on inside its hysteresis band.
        if (awaiting_define) begin
            w.status   = ST_UNDEF;
            w.severity = SEV_INVALID;
        end else if (hh_sev != 0 && (avg >= hihi_level ||
                     (alarm_memory == hihi_level && avg >= hihi_level - hyst_margin))) begin
            w.status     = ST_HIHI;
            w.severity   = hh_sev;
            alarm_memory = hihi_level;
        end else if (ll_sev != 0 && (avg <= lolo_level ||
                     (alarm_memory == lolo_level && avg <= lolo_level + hyst_margin))) begin
            w.status     = ST_LOLO;
            w.severity   = ll_sev;
            alarm_memory = lolo_level;
        end else if (hi_sev != 0 && (avg >= high_level ||
                     (alarm_memory == high_level && avg >= high_level - hyst_margin))) begin
            w.status     = ST_HIGH;
            w.severity   = hi_sev;
            alarm_memory = high_level;
        end else if (lo_sev != 0 && (avg <= low_level ||
                     (alarm_memory == low_level && avg <= low_level + hyst_margin))) begin
            w.status     = ST_LOW;
            w.severity   = lo_sev;
            alarm_memory = low_level;
        end else begin
            alarm_memory = avg;
        end

        w.changed      = (w.status != prior_status) || (w.severity != prior_severity);
        prior_status   = w.status;
        prior_severity = w.severity;

        // Flag a deadband event and move the reference only when the band is exceeded.
        gap = monitored_value - avg;
        if (gap < 0) begin
            gap = -gap;
        end
        if (gap > value_band) begin
            w.value_ev      = 1'b1;
            monitored_value = avg;
        end
        gap = archived_value - avg;
        if (gap < 0) begin
            gap = -gap;
        end
        if (gap > archive_band) begin
            w.archive_ev   = 1'b1;
            archived_value = avg;
        end

        awaiting_define = 1'b0;
        w.average       = avg[SAMPLE_BITS-1:0];
        return w;
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] clamp_sample(input longint v);
        if (v > SAMPLE_MAX) begin
            return SAMPLE_BITS'(SAMPLE_MAX);
        end
        if (v < SAMPLE_MIN) begin
            return SAMPLE_BITS'(SAMPLE_MIN);
        end
        return SAMPLE_BITS'(v);
    endfunction

    // ------------------------------------------------------------------
    // Result checking and prediction, both on the rising edge
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : check_results
        mavg_word_t want;
        if (aresetn) begin
            // Compare the outgoing word first, then queue the prediction for the incoming one.
            if (m_valid && m_ready) begin
                if (awaited_words.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: unexpected result word, average %0d status %0d",
                                 $realtime, m_average, m_alarm_status);
                    end
                end else begin
                    want = awaited_words.pop_front();
                    if (m_average !== want.average || m_alarm_status !== want.status ||
                        m_alarm_severity !== want.severity ||
                        m_alarm_changed !== want.changed ||
                        m_value_event !== want.value_ev ||
                        m_archive_event !== want.archive_ev) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("%0t: exp avg %0d st %0d sev %0d chg %0b vev %0b aev %0b",
                                     $realtime, want.average, want.status, want.severity,
                                     want.changed, want.value_ev, want.archive_ev);
                            $display("%0t: got avg %0d st %0d sev %0d chg %0b vev %0b aev %0b",
                                     $realtime, m_average, m_alarm_status, m_alarm_severity,
                                     m_alarm_changed, m_value_event, m_archive_event);
                        end
                    end
                end
            end
            if (s_valid && s_ready) begin
                awaited_words.push_back(next_average_word(s_sample));
            end
        end
    end

    // Watchdog: end the run once nothing has moved for too long.
    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en || !aresetn) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("TB_ERROR");
        $finish;
    end

    // Receiver: stall according to the current mode; a requested hold-off wins.
    initial begin : receiver
        int rx_phase;
        rx_phase = 0;
        forever begin
            @(negedge aclk);
            if (holdoff_len > 0) begin
                m_ready <= 1'b0;
                repeat (holdoff_len - 1) @(negedge aclk);
                holdoff_len = 0;
            end else begin
                case (rx_mode)
                    RX_ALWAYS:  m_ready <= 1'b1;
                    RX_RANDOM:  m_ready <= ($urandom_range(0, 3) != 0);
                    RX_PATTERN: m_ready <= ((rx_phase % 7) < 3);
                    default:    m_ready <= 1'b1;
                endcase
                rx_phase++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Shared driver tasks; all of them start and end at a falling edge
    // ------------------------------------------------------------------
    task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] value);
        s_valid  <= 1'b1;
        s_sample <= value;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        @(negedge aclk);
        // Drop valid between bursts; hold it otherwise so the next word follows at once.
        if (tx_bursty) begin
            if (burst_left == 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge aclk);
                burst_left = $urandom_range(0, 12);
            end else begin
                burst_left--;
            end
        end
    endtask

    // Drop valid and wait until every awaited word has come back.
    task automatic settle_block();
        s_valid <= 1'b0;
        while (awaited_words.size() != 0) begin
            @(negedge aclk);
        end
        repeat (4) @(negedge aclk);
    endtask

    // Write all registers from cfg_next, one per cycle, and mirror them.
    task automatic apply_config();
        logic [CFG_IDX_W-1:0] reg_idx;
        for (int i = 0; i < NUM_REGS; i++) begin
            reg_idx = CFG_IDX_W'(i);
            cfg_wr_en <= 1'b1;
            cfg_index <= reg_idx;
            cfg_data  <= cfg_next[i];
            @(posedge aclk);
            case (reg_idx)
                REG_HIHI:       hihi_level   = longint'($signed(cfg_next[i]));
                REG_HIGH:       high_level   = longint'($signed(cfg_next[i]));
                REG_LOW:        low_level    = longint'($signed(cfg_next[i]));
                REG_LOLO:       lolo_level   = longint'($signed(cfg_next[i]));
                REG_HYST:       hyst_margin  = longint'(cfg_next[i][HYST_W-1:0]);
                REG_SEVERITIES: limit_sevs   = cfg_next[i][SEV_FLD_W-1:0];
                REG_VALUE_DB:   value_band   = longint'(cfg_next[i]);
                REG_ARCHIVE_DB: archive_band = longint'(cfg_next[i]);
                default: ;
            endcase
            @(negedge aclk);
        end
        cfg_wr_en <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset configuration: first word is undefined; push sample extremes through the sum.
    task automatic test_first_item_and_extremes();
        tx_bursty = 1'b0;
        rx_mode   = RX_ALWAYS;
        send_sample(-24'sd17);          // average -1: truncation toward zero
        send_sample(24'sh7FFFFF);
        send_sample(24'sh800000);
        send_sample(24'sh555555);
        send_sample(24'shAAAAAA);
        send_sample(-24'sd1);
        send_sample(24'sd16);
    endtask

    // Walk the average up through high and hihi, back through the hysteresis band,
    // then down into lolo. Upper bits of hysteresis and severities must be ignored.
    task automatic test_limit_alarms();
        cfg_next[REG_HIHI]       = 24'd1000;
        cfg_next[REG_HIGH]       = 24'd500;
        cfg_next[REG_LOW]        = -24'sd500;
        cfg_next[REG_LOLO]       = -24'sd1000;
        cfg_next[REG_HYST]       = 24'h800064;
        cfg_next[REG_SEVERITIES] = 24'hFFFF5A;
        cfg_next[REG_VALUE_DB]   = 24'd50;
        cfg_next[REG_ARCHIVE_DB] = 24'd200;
        settle_block();
        apply_config();
        tx_bursty = 1'b1;
        rx_mode   = RX_RANDOM;
        send_sample(24'sd9600);
        send_sample(24'sd9600);
        send_sample(24'sd9600);
        send_sample(-24'sd1600);
        send_sample(-24'sd3200);
        send_sample(-24'sd9600);
        send_sample(-24'sd9600);
        send_sample(-24'sd16000);
        send_sample(-24'sd16000);
        send_sample(24'sd1600);
    endtask

    // Widest value deadband never flags; zero archive deadband flags every move.
    task automatic test_deadbands();
        cfg_next[REG_SEVERITIES] = 24'd0;
        cfg_next[REG_VALUE_DB]   = 24'hFFFFFF;
        cfg_next[REG_ARCHIVE_DB] = 24'd0;
        settle_block();
        apply_config();
        rx_mode = RX_PATTERN;
        send_sample(24'sd0);
        send_sample(24'sd0);
        send_sample(24'sd32);
        send_sample(24'sd32);
    endtask

    // Phases of random settings; most words hold the average near a limit for a run.
    task automatic test_random_regimes();
        longint centre;
        longint step;
        longint base;
        longint spread;
        longint level;
        int     run_left;
        for (int p = 0; p < 6; p++) begin
            if (p == 0) begin
                // Extreme limits, hysteresis and deadbands.
                cfg_next[REG_HIHI]       = 24'h7FFFFF;
                cfg_next[REG_HIGH]       = 24'h7FFFF0;
                cfg_next[REG_LOW]        = 24'h800010;
                cfg_next[REG_LOLO]       = 24'h800000;
                cfg_next[REG_HYST]       = 24'hFFFFFF;
                cfg_next[REG_SEVERITIES] = 24'hFFFFFF;
                cfg_next[REG_VALUE_DB]   = 24'hFFFFFF;
                cfg_next[REG_ARCHIVE_DB] = 24'hFFFFFF;
            end else if (p == 1) begin
                // All limits at zero, every limit enabled as invalid.
                cfg_next = '0;
                cfg_next[REG_SEVERITIES] = 24'h0000FF;
            end else begin
                centre = longint'($urandom_range(0, 1 << 23)) - (1 << 22);
                step   = longint'($urandom_range(1, 20000));
                cfg_next[REG_HIHI]       = CFG_DATA_W'(centre + 2 * step);
                cfg_next[REG_HIGH]       = CFG_DATA_W'(centre + step);
                cfg_next[REG_LOW]        = CFG_DATA_W'(centre - step);
                cfg_next[REG_LOLO]       = CFG_DATA_W'(centre - 2 * step);
                cfg_next[REG_HYST]       = CFG_DATA_W'($urandom_range(0, 32'(step)))
                                           | CFG_DATA_W'($urandom_range(0, 1) << 23);
                cfg_next[REG_SEVERITIES] = CFG_DATA_W'($urandom);
                cfg_next[REG_VALUE_DB]   = ($urandom_range(0, 3) == 0) ? 24'hFFFFFF
                                           : CFG_DATA_W'($urandom_range(0, 3000));
                cfg_next[REG_ARCHIVE_DB] = ($urandom_range(0, 3) == 0) ? 24'd0
                                           : CFG_DATA_W'($urandom_range(0, 3000));
            end
            settle_block();
            apply_config();

            // Keep one phase free of idling on both sides.
            if (p == 2) begin
                rx_mode   = RX_ALWAYS;
                tx_bursty = 1'b0;
            end else begin
                rx_mode   = rx_mode_t'($urandom_range(0, 2));
                tx_bursty = $urandom_range(0, 1);
            end

            run_left = 0;
            for (int n = 0; n < 80; n++) begin
                if ($urandom_range(0, 3) == 0) begin
                    send_sample(SAMPLE_BITS'($urandom));
                end else begin
                    if (run_left == 0) begin
                        // Pick a level around a limit or a random base, about its capped hysteresis reach.
                        case ($urandom_range(0, 4))
                            0:       base = hihi_level;
                            1:       base = high_level;
                            2:       base = low_level;
                            3:       base = lolo_level;
                            default: base = longint'($signed(SAMPLE_BITS'($urandom)));
                        endcase
                        spread   = ((hyst_margin > 4096) ? 4096 : hyst_margin) * 2 + 16;
                        level    = base + longint'($urandom_range(0, 32'(spread))) - spread / 2;
                        run_left = $urandom_range(4, 30);
                    end
                    run_left--;
                    send_sample(clamp_sample(level + longint'($urandom_range(0, 6)) - 3));
                end
            end
        end
    endtask

    // Hold the receiver off for a long stretch while words keep coming, so the
    // block fills and drops s_ready.
    task automatic test_output_backpressure();
        settle_block();
        tx_bursty   = 1'b0;
        rx_mode     = RX_RANDOM;
        holdoff_len = 300;
        for (int n = 0; n < 40; n++) begin
            send_sample(SAMPLE_BITS'($urandom));
        end
    endtask

    initial begin : run_tests
        for (int i = 0; i < WINDOW; i++) begin
            window_ring[i] = '0;
        end
        // Hold reset, then release it once.
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_first_item_and_extremes();
        test_limit_alarms();
        test_deadbands();
        test_random_regimes();
        test_output_backpressure();

        settle_block();
        repeat (8) @(posedge aclk);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule

>>> sim.f
rtl/mavg_pkg.sv
rtl/moving_average_with_alarms.sv
rtl/mavg_checker.sv
dv/tb.sv
